// ===== hdl/haas_stereo_widener_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Haas stereo widener
// Clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef HAAS_STEREO_WIDENER_TOP_ASSERT_SVH
`define HAAS_STEREO_WIDENER_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define HSW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define HSW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/hsw_pkg.sv =====
// ---------------------------------------------------------------------------
// hsw_pkg
// Shared types and constants of the Haas stereo widener.
// ---------------------------------------------------------------------------
package hsw_pkg;

  localparam int DELAY_DEPTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int COEF_BITS      = 24;  // signed Q8.16
  localparam int COEF_FRAC      = 16;
  localparam int DELAY_BITS     = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [COEF_BITS-1:0] DIRECT_GAIN_RESET = 24'h010000;  // 1.0

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SOURCE_SELECT = 3'd0,
    REG_DIRECT_GAIN   = 3'd1,
    REG_DELAY_A       = 3'd2,
    REG_DELAY_B       = 3'd3,
    REG_COEF_A_LEFT   = 3'd4,
    REG_COEF_B_LEFT   = 3'd5,
    REG_COEF_A_RIGHT  = 3'd6,
    REG_COEF_B_RIGHT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SRC_LEFT      = 2'd0,
    SRC_RIGHT     = 2'd1,
    SRC_HALF_SUM  = 2'd2,
    SRC_HALF_DIFF = 2'd3
  } src_sel_t;

endpackage

// ===== hdl/haas_stereo_widener_top.sv =====
// ---------------------------------------------------------------------------
// haas_stereo_widener_top
// Haas-effect stereo widener: mid source, ring delay line, two weighted taps.
// ---------------------------------------------------------------------------
// One item is a stereo pair (s_tdata = left_in, right_in; s_tuser = bypass).
// The mid signal (left, right, half sum or half difference) is written into
// a DELAY_DEPTH-entry ring memory while taps a and b are read from the same
// memory in the same cycle; a tap whose delay is zero (modulo the depth)
// takes the sample being written. Each output is direct_gain*mid plus the
// two weighted taps, rounded half up at bit 16 and saturated to SAMPLE_BITS.
// Throughput is one item per clock while s_tready is high and m_tready does
// not hold the output: the memory does one write and two reads per cycle and
// all later stages are registered. There are four register stages (memory
// read at the accept edge, products, sum, round/saturate), ending at m_tvalid.
// After reset the memory is zeroed by a clearing pass over every entry,
// during which s_tready is low; configuration writes are taken meanwhile.
// A write to delay_a or delay_b starts a modulo-depth reduction of the
// tap delays (reciprocal quotient, then subtract), and s_tready stays low
// until it ends. Write registers only while the block is idle. bypass=1
// copies the inputs to the outputs; the delay line still advances.
// ---------------------------------------------------------------------------
module haas_stereo_widener_top
  import hsw_pkg::*;
#(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // left_in, right_in
  input  logic                                   s_tuser,   // bypass
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // left_out, right_out
  // configuration write port
  input  logic                                   cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
  input  logic [CFG_DATA_BITS-1:0]               cfg_data
);

  localparam int SB         = SAMPLE_BITS;
  localparam int TDATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int AW         = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int PW         = COEF_BITS + SAMPLE_BITS;   // one product
  localparam int ACW        = PW + 2;                     // sum of three
  localparam int RNDW       = ACW - COEF_FRAC;            // after rounding shift
  localparam int RSH        = DELAY_BITS + AW;            // reciprocal shift
  localparam int RMW        = DELAY_BITS + 2;             // reciprocal width
  localparam int RPW        = DELAY_BITS + RMW;           // delay * reciprocal
  localparam int QDW        = DELAY_BITS + AW + 1;        // quotient * depth
  localparam int RCW        = 2;

  localparam logic [AW-1:0]  ADDR_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]    DEPTH_X   = (AW+1)'(DELAY_DEPTH);
  localparam logic [QDW-1:0] DEPTH_Q   = QDW'(DELAY_DEPTH);
  localparam logic [RMW-1:0] RECIP     =
    RMW'(((64'd1 << RSH) + 64'(DELAY_DEPTH) - 64'd1) / 64'(DELAY_DEPTH));
  localparam logic [RCW-1:0] RED_STEPS = RCW'(2);
  localparam logic signed [ACW-1:0] ROUND_BIAS = ACW'(1 << (COEF_FRAC - 1));
  localparam logic signed [SB-1:0]  SAT_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]  SAT_MIN = {1'b1, {(SB-1){1'b0}}};

  // ---------------- configuration registers ----------------
  src_sel_t                      source_select;
  logic signed [COEF_BITS-1:0]   direct_gain;
  logic [DELAY_BITS-1:0]         delay_a;     // reduced modulo depth in place
  logic [DELAY_BITS-1:0]         delay_b;
  logic signed [COEF_BITS-1:0]   coef_a_left;
  logic signed [COEF_BITS-1:0]   coef_b_left;
  logic signed [COEF_BITS-1:0]   coef_a_right;
  logic signed [COEF_BITS-1:0]   coef_b_right;
  logic [RCW-1:0]                red_cnt;     // remaining reduction steps

  // Modulo by reciprocal: step one takes the quotient, step two subtracts
  // quotient * depth. Exact for every 12-bit delay.
  logic [RPW-1:0]        prod_a, prod_b;
  logic [DELAY_BITS-1:0] quo_a, quo_b;
  assign prod_a = RPW'(delay_a) * RPW'(RECIP);
  assign prod_b = RPW'(delay_b) * RPW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_select <= SRC_HALF_SUM;
      direct_gain   <= DIRECT_GAIN_RESET;
      delay_a       <= '0;
      delay_b       <= '0;
      coef_a_left   <= '0;
      coef_b_left   <= '0;
      coef_a_right  <= '0;
      coef_b_right  <= '0;
      red_cnt       <= '0;
      quo_a         <= '0;
      quo_b         <= '0;
    end else begin
      if (red_cnt != '0) begin
        red_cnt <= red_cnt - 1'b1;
      end
      if (red_cnt == RED_STEPS) begin
        quo_a <= DELAY_BITS'(prod_a >> RSH);
        quo_b <= DELAY_BITS'(prod_b >> RSH);
      end
      if (red_cnt == RCW'(1)) begin
        delay_a <= DELAY_BITS'(QDW'(delay_a) - QDW'(quo_a) * DEPTH_Q);
        delay_b <= DELAY_BITS'(QDW'(delay_b) - QDW'(quo_b) * DEPTH_Q);
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_SOURCE_SELECT: source_select <= src_sel_t'(cfg_data[1:0]);
          REG_DIRECT_GAIN:   direct_gain   <= cfg_data[COEF_BITS-1:0];
          REG_DELAY_A: begin
            delay_a <= cfg_data[DELAY_BITS-1:0];
            red_cnt <= RED_STEPS;
          end
          REG_DELAY_B: begin
            delay_b <= cfg_data[DELAY_BITS-1:0];
            red_cnt <= RED_STEPS;
          end
          REG_COEF_A_LEFT:   coef_a_left   <= cfg_data[COEF_BITS-1:0];
          REG_COEF_B_LEFT:   coef_b_left   <= cfg_data[COEF_BITS-1:0];
          REG_COEF_A_RIGHT:  coef_a_right  <= cfg_data[COEF_BITS-1:0];
          REG_COEF_B_RIGHT:  coef_b_right  <= cfg_data[COEF_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- pipeline flow control ----------------
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, adv4;
  logic clr_active;
  logic [AW-1:0] clr_addr;
  logic s_acc;

  assign adv4     = !m_tvalid || m_tready;
  assign rdy3     = !v3 || adv4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1 && !clr_active && (red_cnt == '0);
  assign s_acc    = s_tvalid && s_tready;

  // ---------------- mid source ----------------
  logic signed [SB-1:0] left_in, right_in;
  logic                 bypass;
  logic signed [SB:0]   half_sum, half_diff;
  logic signed [SB-1:0] mid;

  assign left_in   = s_tdata[SB-1:0];
  assign right_in  = s_tdata[2*SB-1:SB];
  assign bypass    = s_tuser;
  assign half_sum  = {left_in[SB-1], left_in} + {right_in[SB-1], right_in};
  assign half_diff = {left_in[SB-1], left_in} - {right_in[SB-1], right_in};

  always_comb begin
    case (source_select)
      SRC_LEFT:     mid = left_in;
      SRC_RIGHT:    mid = right_in;
      SRC_HALF_SUM: mid = half_sum[SB:1];   // floor shift
      default:      mid = half_diff[SB:1];
    endcase
  end

  // ---------------- tap addresses ----------------
  logic [AW-1:0] wp;
  logic [AW:0]   diff_a, diff_b;
  logic [AW-1:0] pa, pb;

  assign diff_a = {1'b0, wp} - (AW+1)'(delay_a);
  assign diff_b = {1'b0, wp} - (AW+1)'(delay_b);
  assign pa = diff_a[AW] ? AW'(diff_a + DEPTH_X) : diff_a[AW-1:0];
  assign pb = diff_b[AW] ? AW'(diff_b + DEPTH_X) : diff_b[AW-1:0];

  // ---------------- delay line memory ----------------
  logic signed [SB-1:0] mem [DELAY_DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [SB-1:0] mem_wdata;

  assign mem_we    = clr_active || s_acc;
  assign mem_waddr = clr_active ? clr_addr : wp;
  assign mem_wdata = clr_active ? '0 : mid;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // clearing pass and write position
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      wp         <= '0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_LAST) begin
          clr_active <= 1'b0;
        end
      end
      if (s_acc) begin
        wp <= (wp == ADDR_LAST) ? '0 : wp + 1'b1;
      end
    end
  end

  // ---------------- stage 1: registered reads ----------------
  logic signed [SB-1:0] mid1, ta1, tb1, l1, r1;
  logic                 fa1, fb1, byp1;

  always_ff @(posedge clk) begin
    if (s_acc) begin
      ta1  <= mem[pa];
      tb1  <= mem[pb];
      fa1  <= (pa == wp);   // zero delay: forward the sample being written
      fb1  <= (pb == wp);
      mid1 <= mid;
      l1   <= left_in;
      r1   <= right_in;
      byp1 <= bypass;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [SB-1:0] ta, tb;
  logic signed [PW-1:0] dm2, al2, bl2, ar2, br2;
  logic signed [SB-1:0] l2, r2;
  logic                 byp2;

  assign ta = fa1 ? mid1 : ta1;
  assign tb = fb1 ? mid1 : tb1;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      dm2  <= direct_gain  * mid1;
      al2  <= coef_a_left  * ta;
      bl2  <= coef_b_left  * tb;
      ar2  <= coef_a_right * ta;
      br2  <= coef_b_right * tb;
      l2   <= l1;
      r2   <= r1;
      byp2 <= byp1;
    end
  end

  // ---------------- stage 3: sums with rounding bias ----------------
  logic signed [ACW-1:0] accl3, accr3;
  logic signed [SB-1:0]  l3, r3;
  logic                  byp3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      accl3 <= ACW'(dm2) + ACW'(al2) + ACW'(bl2) + ROUND_BIAS;
      accr3 <= ACW'(dm2) + ACW'(ar2) + ACW'(br2) + ROUND_BIAS;
      l3    <= l2;
      r3    <= r2;
      byp3  <= byp2;
    end
  end

  // ---------------- stage 4: shift, saturate, output register ----------------
  logic signed [RNDW-1:0] rndl, rndr;
  logic                   fitl, fitr;
  logic signed [SB-1:0]   satl, satr;
  logic signed [SB-1:0]   left_out, right_out;

  assign rndl = accl3[ACW-1:COEF_FRAC];
  assign rndr = accr3[ACW-1:COEF_FRAC];
  assign fitl = (&rndl[RNDW-1:SB-1]) || !(|rndl[RNDW-1:SB-1]);
  assign fitr = (&rndr[RNDW-1:SB-1]) || !(|rndr[RNDW-1:SB-1]);
  assign satl = fitl ? rndl[SB-1:0] : (rndl[RNDW-1] ? SAT_MIN : SAT_MAX);
  assign satr = fitr ? rndr[SB-1:0] : (rndr[RNDW-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (adv4) begin
      left_out  <= byp3 ? l3 : satl;
      right_out <= byp3 ? r3 : satr;
    end
  end

  assign m_tdata = TDATA_BITS'({right_out, left_out});

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_acc;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (adv4) m_tvalid <= v3;
    end
  end

  // ---------------- assertions ----------------
`include "haas_stereo_widener_top_assert.svh"

  `HSW_ASSERT_ALWAYS(a_delay_reduced, (red_cnt != '0) || ((32'(delay_a) < DELAY_DEPTH) && (32'(delay_b) < DELAY_DEPTH)), "tap delay not reduced below depth")
  `HSW_ASSERT_SAME(a_tap_in_range, s_acc, (32'(pa) < DELAY_DEPTH) && (32'(pb) < DELAY_DEPTH), "tap address outside delay line")
  `HSW_ASSERT_NEXT(a_wp_advance, s_acc && (wp != ADDR_LAST), wp == $past(wp) + 1'b1, "write position did not advance by one")
  `HSW_ASSERT_SAME(a_no_accept_clear, clr_active, !s_acc && mem_we, "item accepted during clearing pass")

endmodule
